// ===== rtl/hashed_name_registry_core_defines.svh =====
// ---------------------------------------------------------------------------
// hashed name registry assertion macros
// shared property wrappers clocked on clk with synchronous active-low reset
// ---------------------------------------------------------------------------
`ifndef HASHED_NAME_REGISTRY_CORE_DEFINES_SVH
`define HASHED_NAME_REGISTRY_CORE_DEFINES_SVH

// property checked outside reset
`define HNR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define HNR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hnr_pkg.sv =====
// ---------------------------------------------------------------------------
// hnr_pkg
// shared types, codes and constants of the hashed name registry
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hnr_pkg;

  // default sizes
  localparam int DEF_TABLE_SLOTS = 128;
  localparam int DEF_NAME_BYTES  = 8;
  localparam int DEF_HANDLE_BITS = 16;

  // fixed field widths
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 88;
  localparam int OUT_W    = 24;

  // fnv-1a
  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam logic [31:0] MARK_EMPTY = 32'h0000_0000;
  localparam logic [31:0] MARK_TOMB  = 32'hFFFF_FFFF;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic                load;
    logic                hash_step;
    logic                mod_start;
    logic                mod_step;
    logic                probe_start;
    logic                rd;
    logic                adv;
    logic                note_tomb;
    logic                wr_ins;
    logic                wr_tomb;
    logic                clr_step;
    logic                res_set;
    logic [STATUS_W-1:0] res_status;
    logic                res_found;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              hash_done;
    logic              mod_done;
    logic              clr_done;
    logic              load_full;
    logic              is_empty;
    logic              is_tomb;
    logic              hash_eq;
    logic              name_eq;
    logic              handle_eq;
    logic              probe_last;
  } sts_t;

endpackage

// ===== rtl/hnr_datapath.sv =====
// ---------------------------------------------------------------------------
// hnr_datapath
// hashing, start index reduction, slot memories, probe pointer and results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hnr_datapath #(
  parameter int TABLE_SLOTS = hnr_pkg::DEF_TABLE_SLOTS,
  parameter int NAME_BYTES  = hnr_pkg::DEF_NAME_BYTES,
  parameter int HANDLE_BITS = hnr_pkg::DEF_HANDLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hnr_pkg::cmd_t                 cmd,
  output hnr_pkg::sts_t                 sts,
  input  logic [hnr_pkg::IN_W-1:0]      in_tdata,
  output logic [hnr_pkg::OUT_W-1:0]     out_tdata
);

  localparam int IDXW   = $clog2(TABLE_SLOTS);
  localparam int NAMEW  = NAME_BYTES * 8;
  localparam int HB     = (HANDLE_BITS < hnr_pkg::HANDLE_W) ? HANDLE_BITS : hnr_pkg::HANDLE_W;
  localparam int BCW    = $clog2(NAME_BYTES + 1);
  localparam int OCCW   = $clog2(TABLE_SLOTS + 1);
  localparam int LIMIT  = (TABLE_SLOTS * 3) / 4;
  localparam int SELW   = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  // ceil(2^(32+IDXW) / TABLE_SLOTS), exact quotient for any 32-bit hash
  localparam logic [32:0] RECIP =
    33'(((64'd1 << (32 + IDXW)) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

  // request registers
  logic [hnr_pkg::MODE_W-1:0] mode_r;
  logic [NAMEW-1:0]           key_r;
  logic [HB-1:0]              hd_r;
  logic [NAMEW-1:0]           name_r;
  logic [31:0]                hash_r;
  logic [BCW-1:0]             bcnt_r;

  // start index reduction
  logic [IDXW:0]              mod_r;
  logic [31:0]                q_r;
  logic [1:0]                 mleft_r;

  // probe state
  logic [IDXW-1:0]            idx_r;
  logic [IDXW-1:0]            pcnt_r;
  logic [IDXW-1:0]            tomb_r;
  logic                       have_tomb_r;
  logic [IDXW-1:0]            clr_r;
  logic [OCCW-1:0]            occ_r;

  // slot memories
  logic [31:0]                hash_mem [TABLE_SLOTS];
  logic [NAMEW-1:0]           name_mem [TABLE_SLOTS];
  logic [HB-1:0]              hd_mem   [TABLE_SLOTS];
  logic [31:0]                rd_hash_r;
  logic [NAMEW-1:0]           rd_name_r;
  logic [HB-1:0]              rd_hd_r;

  // results
  logic [hnr_pkg::STATUS_W-1:0] status_r;
  logic [hnr_pkg::HANDLE_W-1:0] found_r;

  // current hash byte
  logic [7:0]     cur_byte;
  logic [31:0]    hash_step_val;
  logic [31:0]    hash_fix;
  logic [64:0]    recip_prod;
  logic [31:0]    rem_full;
  logic [IDXW:0]  mod_nxt;
  logic [IDXW-1:0] wr_addr;
  logic [IDXW-1:0] idx_inc;

  always_comb begin
    cur_byte = 8'd0;
    if (bcnt_r < BCW'(NAME_BYTES)) begin
      cur_byte = key_r[8*bcnt_r[SELW-1:0] +: 8];
    end
  end

  assign hash_step_val = (hash_r ^ {24'd0, cur_byte}) * hnr_pkg::FNV_PRIME;

  // keep the marker values free
  always_comb begin
    hash_fix = hash_r;
    if (hash_r == hnr_pkg::MARK_EMPTY) begin
      hash_fix = 32'd1;
    end else if (hash_r == hnr_pkg::MARK_TOMB) begin
      hash_fix = hnr_pkg::MARK_TOMB - 32'd1;
    end
  end

  // remainder by reciprocal: quotient, then remainder, then one correction
  assign recip_prod = 65'(hash_r) * 65'(RECIP);
  assign rem_full   = hash_r - q_r * 32'(TABLE_SLOTS);
  assign mod_nxt    = (mod_r >= (IDXW+1)'(TABLE_SLOTS)) ?
                      mod_r - (IDXW+1)'(TABLE_SLOTS) : mod_r;

  assign idx_inc = (idx_r == IDXW'(TABLE_SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign wr_addr = have_tomb_r ? tomb_r : idx_r;

  // request, hash and probe registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_tdata[1:0];
      key_r  <= in_tdata[2 +: NAMEW];
      hd_r   <= in_tdata[66 +: HB];
      name_r <= '0;
      hash_r <= hnr_pkg::FNV_BASIS;
      bcnt_r <= '0;
    end
    if (cmd.hash_step) begin
      name_r[8*bcnt_r[SELW-1:0] +: 8] <= cur_byte;
      hash_r <= hash_step_val;
      bcnt_r <= bcnt_r + 1'b1;
    end
    if (cmd.mod_start) begin
      hash_r <= hash_fix;
      mod_r  <= '0;
    end
    if (cmd.mod_step) begin
      if (mleft_r == 2'd3) begin
        q_r <= 32'(recip_prod >> (32 + IDXW));
      end else if (mleft_r == 2'd2) begin
        mod_r <= rem_full[IDXW:0];
      end else begin
        mod_r <= mod_nxt;
      end
    end
    if (cmd.probe_start) begin
      idx_r       <= mod_r[IDXW-1:0];
      pcnt_r      <= '0;
      have_tomb_r <= 1'b0;
    end
    if (cmd.note_tomb && !have_tomb_r) begin
      tomb_r      <= idx_r;
      have_tomb_r <= 1'b1;
    end
    if (cmd.adv) begin
      idx_r  <= idx_inc;
      pcnt_r <= pcnt_r + 1'b1;
    end
    if (cmd.res_set) begin
      status_r <= cmd.res_status;
      found_r  <= cmd.res_found ? hnr_pkg::HANDLE_W'(rd_hd_r) : '0;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r   <= '0;
      occ_r   <= '0;
      mleft_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.mod_start) begin
        mleft_r <= 2'd3;
      end else if (cmd.mod_step) begin
        mleft_r <= mleft_r - 1'b1;
      end
      if (cmd.wr_ins) begin
        occ_r <= occ_r + 1'b1;
      end else if (cmd.wr_tomb && occ_r != '0) begin
        occ_r <= occ_r - 1'b1;
      end
    end
  end

  // slot memories, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      hash_mem[clr_r] <= hnr_pkg::MARK_EMPTY;
    end else if (cmd.wr_tomb) begin
      hash_mem[idx_r] <= hnr_pkg::MARK_TOMB;
    end else if (cmd.wr_ins) begin
      hash_mem[wr_addr] <= hash_r;
    end
    if (cmd.wr_ins) begin
      name_mem[wr_addr] <= name_r;
      hd_mem[wr_addr]   <= hd_r;
    end
    if (cmd.rd) begin
      rd_hash_r <= hash_mem[idx_r];
      rd_name_r <= name_mem[idx_r];
      rd_hd_r   <= hd_mem[idx_r];
    end
  end

  // status to controller
  always_comb begin
    sts.mode       = mode_r;
    sts.hash_done  = (bcnt_r == BCW'(NAME_BYTES)) || (cur_byte == 8'd0);
    sts.mod_done   = (mleft_r == 2'd0);
    sts.clr_done   = (clr_r == IDXW'(TABLE_SLOTS - 1));
    sts.load_full  = (occ_r >= OCCW'(LIMIT));
    sts.is_empty   = (rd_hash_r == hnr_pkg::MARK_EMPTY);
    sts.is_tomb    = (rd_hash_r == hnr_pkg::MARK_TOMB);
    sts.hash_eq    = (rd_hash_r == hash_r);
    sts.name_eq    = (rd_name_r == name_r);
    sts.handle_eq  = (rd_hd_r == hd_r);
    sts.probe_last = (pcnt_r == IDXW'(TABLE_SLOTS - 1));
  end

  assign out_tdata = {6'd0, found_r, status_r};

endmodule

// ===== rtl/hnr_ctrl.sv =====
// ---------------------------------------------------------------------------
// hnr_ctrl
// request sequencer: clear pass, hash, index reduction, probe and reply
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hashed_name_registry_core_defines.svh"

module hnr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  hnr_pkg::sts_t sts,
  output hnr_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_CHECK, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.hash_done) begin
          cmd.mod_start = 1'b1;
          state_nxt     = S_MOD;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_MOD: begin
        if (!sts.mod_done) begin
          cmd.mod_step = 1'b1;
        end else if (sts.mode != hnr_pkg::MODE_INSERT && sts.mode != hnr_pkg::MODE_REMOVE &&
                     sts.mode != hnr_pkg::MODE_FIND) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = hnr_pkg::ST_NONE;
          state_nxt      = S_DONE;
        end else if (sts.mode == hnr_pkg::MODE_INSERT && sts.load_full) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = hnr_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          cmd.probe_start = 1'b1;
          state_nxt       = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt   = S_DONE;
        cmd.res_set = 1'b1;
        priority if (sts.mode == hnr_pkg::MODE_INSERT) begin
          priority if (sts.is_empty) begin
            cmd.wr_ins     = 1'b1;
            cmd.res_status = hnr_pkg::ST_OK;
          end else if (sts.hash_eq && sts.name_eq) begin
            cmd.res_status = hnr_pkg::ST_DUP;
          end else if (sts.probe_last) begin
            cmd.res_status = hnr_pkg::ST_FULL;
          end else begin
            cmd.res_set   = 1'b0;
            cmd.adv       = 1'b1;
            cmd.note_tomb = sts.is_tomb;
            state_nxt     = S_READ;
          end
        end else if (sts.mode == hnr_pkg::MODE_REMOVE) begin
          priority if (sts.is_empty) begin
            cmd.res_status = hnr_pkg::ST_NONE;
          end else if (sts.hash_eq && sts.handle_eq) begin
            cmd.wr_tomb    = 1'b1;
            cmd.res_status = hnr_pkg::ST_OK;
          end else if (sts.probe_last) begin
            cmd.res_status = hnr_pkg::ST_NONE;
          end else begin
            cmd.res_set = 1'b0;
            cmd.adv     = 1'b1;
            state_nxt   = S_READ;
          end
        end else begin
          priority if (sts.is_empty) begin
            cmd.res_status = hnr_pkg::ST_NONE;
          end else if (sts.hash_eq && sts.name_eq) begin
            cmd.res_status = hnr_pkg::ST_OK;
            cmd.res_found  = 1'b1;
          end else if (sts.probe_last) begin
            cmd.res_status = hnr_pkg::ST_NONE;
          end else begin
            cmd.res_set = 1'b0;
            cmd.adv     = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      S_DONE: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  `HNR_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!in_tready && !out_tvalid), "busy after reset")
  `HNR_ASSERT(a_no_overlap, !(in_tready && out_tvalid), "input and reply open together")
  `HNR_ASSERT(a_accept_closes, (in_tvalid && in_tready) |=> !in_tready, "second request taken")
  `HNR_ASSERT(a_reply_reopens, (out_tvalid && out_tready) |=> in_tready, "not idle after reply")
  `HNR_ASSERT(a_one_write, !(cmd.wr_ins && cmd.wr_tomb), "insert and remove write together")

endmodule

// ===== rtl/hashed_name_registry_core.sv =====
// ---------------------------------------------------------------------------
// hashed_name_registry_core
// name to handle registry in an open-addressing table with linear probing
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over every slot with
// in_tready low. Each request then passes through an accept step, hashing
// (one byte through the FNV multiplier a cycle, stopping at a zero byte or
// after NAME_BYTES bytes), reduction of the hash to a start slot (reciprocal
// multiply, remainder, final correction), then for each slot probed a
// registered read of the slot memories and a compare, and a reply held until
// out_tready; an insert into a table at its load limit, or a request with an
// unused mode code, skips the probe. One request is handled at a time: a new
// request is not accepted until the reply to the last one has been taken.
`timescale 1ns / 1ps

module hashed_name_registry_core #(
  parameter int TABLE_SLOTS = hnr_pkg::DEF_TABLE_SLOTS,
  parameter int NAME_BYTES  = hnr_pkg::DEF_NAME_BYTES,
  parameter int HANDLE_BITS = hnr_pkg::DEF_HANDLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [hnr_pkg::IN_W-1:0]  in_tdata,   // mode[1:0], name_key[65:2], handle[81:66]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [hnr_pkg::OUT_W-1:0] out_tdata   // status[1:0], found_handle[17:2]
);

  hnr_pkg::cmd_t cmd;
  hnr_pkg::sts_t sts;

  // sequencer
  hnr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // table and arithmetic
  hnr_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .NAME_BYTES  (NAME_BYTES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule
